@@ rtl/core/tcsm_pkg.sv @@
// tcsm_pkg: shared constants, types and helpers for the touch calibration mapper.
// No dependencies; used by every file in rtl/core.
package tcsm_pkg;

	localparam int RAW_BITS_DEF = 12;
	localparam int MARGIN_W     = 10;
	localparam int SIZE_W       = 13;
	localparam int PIX_W        = 12;
	localparam int SPAN_W       = 13;
	localparam int CFG_IDX_W    = 3;
	localparam int SIZE_MAX_PIX = 4096;

	localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MARG_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MARG_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd7;

	localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;
	localparam logic [SIZE_W-1:0]   WIDTH_RST  = 13'd320;
	localparam logic [SIZE_W-1:0]   HEIGHT_RST = 13'd240;

	// valid bit of a pipeline slot and whether both pen-down flags were set
	typedef struct packed {
		logic vld;
		logic ok;
	} meta_t;

	// largest pixel index after clamping the size to 1..4096
	function automatic logic [PIX_W-1:0] size_m1(input logic [SIZE_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s == '0) begin
			r = '0;
		end else if (s > SIZE_W'(SIZE_MAX_PIX)) begin
			r = '1;
		end else begin
			r = PIX_W'(s - SIZE_W'(1));
		end
		return r;
	endfunction

endpackage

@@ rtl/core/tcsm_front.sv @@
// tcsm_front: per-axis front end: offset, product with span, magnitude and sign.
// Depends on tcsm_pkg. Three register stages.
module tcsm_front #(
	parameter int RAW_BITS = tcsm_pkg::RAW_BITS_DEF,
	parameter int NW       = RAW_BITS + 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  tcsm_pkg::meta_t                meta_in,
	input  logic [RAW_BITS-1:0]            raw,
	input  logic [RAW_BITS-1:0]            low,
	input  logic [RAW_BITS-1:0]            high,
	input  logic [tcsm_pkg::MARGIN_W-1:0]  margin,
	input  logic [tcsm_pkg::PIX_W-1:0]     szm1,
	output tcsm_pkg::meta_t                meta_out,
	output logic [NW-1:0]                  num_mag,
	output logic                           num_neg
);

	localparam int DW = RAW_BITS + 1;
	localparam int PW = DW + tcsm_pkg::SPAN_W;

	tcsm_pkg::meta_t                    meta_s1, meta_s2, meta_s3;
	logic signed [DW-1:0]               diff_s1;
	logic signed [tcsm_pkg::SPAN_W-1:0] span_s1;
	logic signed [PW-1:0]               prod_s2;
	logic [NW-1:0]                      mag_s3;
	logic                               neg_s3;
	logic signed [DW-1:0]               diff_c;
	logic signed [tcsm_pkg::SPAN_W-1:0] span_c;
	logic signed [PW-1:0]               abs_c;

	assign diff_c = $signed({1'b0, raw}) - $signed({1'b0, low});
	assign span_c = $signed({1'b0, szm1}) - $signed({2'b00, margin, 1'b0});
	assign abs_c  = prod_s2[PW-1] ? -prod_s2 : prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_c;
			span_s1 <= span_c;
			prod_s2 <= PW'(diff_s1) * PW'(span_s1);
			mag_s3  <= abs_c[NW-1:0];
			neg_s3  <= prod_s2[PW-1] ^ (high < low);
		end
	end

	assign meta_out = meta_s3;
	assign num_mag  = mag_s3;
	assign num_neg  = neg_s3;

endmodule

@@ rtl/core/tcsm_div.sv @@
// tcsm_div: pipelined restoring divider of magnitudes, one quotient bit per stage.
// Depends on tcsm_pkg.
module tcsm_div #(
	parameter int NW = 24,
	parameter int DW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tcsm_pkg::meta_t meta_in,
	input  logic            neg_in,
	input  logic [NW-1:0]   n_in,
	input  logic [DW-1:0]   d,
	output tcsm_pkg::meta_t meta_out,
	output logic            neg_out,
	output logic [NW-1:0]   q_out
);

	tcsm_pkg::meta_t meta_s [1:NW];
	logic            neg_s  [1:NW];
	logic [DW-1:0]   rem_s  [1:NW];
	logic [NW-1:0]   nq_s   [1:NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		tcsm_pkg::meta_t meta_p;
		logic            neg_p;
		logic [DW-1:0]   rem_p;
		logic [NW-1:0]   nq_p;
		logic [DW:0]     trial;
		logic            take;
		logic [DW-1:0]   rem_n;

		if (k == 0) begin : g_head
			assign meta_p = meta_in;
			assign neg_p  = neg_in;
			assign rem_p  = '0;
			assign nq_p   = n_in;
		end else begin : g_body
			assign meta_p = meta_s[k];
			assign neg_p  = neg_s[k];
			assign rem_p  = rem_s[k];
			assign nq_p   = nq_s[k];
		end

		always_comb begin
			trial = {rem_p, nq_p[NW-1]};
			take  = trial >= {1'b0, d};
			rem_n = take ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_s[k+1] <= '0;
			end else if (en) begin
				meta_s[k+1] <= meta_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_p;
				rem_s[k+1] <= rem_n;
				nq_s[k+1]  <= {nq_p[NW-2:0], take};
			end
		end
	end

	assign meta_out = meta_s[NW];
	assign neg_out  = neg_s[NW];
	assign q_out    = nq_s[NW];

endmodule

@@ rtl/core/tcsm_back.sv @@
// tcsm_back: per-axis back end: signed quotient, margin offset, clamp to the screen.
// Depends on tcsm_pkg. Two register stages; the second is the output register.
module tcsm_back #(
	parameter int NW = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  tcsm_pkg::meta_t               meta_in,
	input  logic                          neg_in,
	input  logic [NW-1:0]                 q_in,
	input  logic                          den_zero,
	input  logic [tcsm_pkg::MARGIN_W-1:0] margin,
	input  logic [tcsm_pkg::PIX_W-1:0]    szm1,
	output tcsm_pkg::meta_t               meta_out,
	output logic [tcsm_pkg::PIX_W-1:0]    pix
);

	localparam int VW = NW + 2;

	tcsm_pkg::meta_t             meta_s1, meta_s2;
	logic signed [NW:0]          qs_s1;
	logic [tcsm_pkg::PIX_W-1:0]  pix_s2;
	logic signed [VW-1:0]        v_c;
	logic [tcsm_pkg::PIX_W-1:0]  pix_c;

	always_comb begin
		v_c = VW'(qs_s1) + $signed(VW'({1'b0, margin}));
		if (!meta_s1.ok || den_zero || v_c < 0) begin
			pix_c = '0;
		end else if (v_c > $signed(VW'({1'b0, szm1}))) begin
			pix_c = szm1;
		end else begin
			pix_c = v_c[tcsm_pkg::PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
		end else if (en) begin
			meta_s1 <= meta_in;
			meta_s2 <= meta_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s1  <= neg_in ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
			pix_s2 <= pix_c;
		end
	end

	assign meta_out = meta_s2;
	assign pix      = pix_s2;

endmodule

@@ rtl/core/touch_calibrated_screen_map_top.sv @@
// touch_calibrated_screen_map_top: configuration registers and two axis pipelines.
// Depends on tcsm_pkg, tcsm_front, tcsm_div, tcsm_back.
//
//  channel  handshake            payload
//  in       in_valid/in_ready    pen_down_before, raw_x, raw_y, pen_down_after
//  out      out_valid/out_ready  valid_res, screen_x, screen_y
//  cfg      cfg_we               cfg_addr, cfg_wdata
//
// One request enters per cycle while out is not stalled; the pipeline has 3 front stages,
// RAW_BITS + 12 divider stages (one quotient bit each) and 2 back stages.
// arst_n clears all valid bits and loads the register reset values.
// A stall on out holds the whole pipeline; in_ready is low only while the output
// register holds an untaken result.
module touch_calibrated_screen_map_top #(
	parameter int RAW_BITS = tcsm_pkg::RAW_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        pen_down_before,
	input  logic [RAW_BITS-1:0]                         raw_x,
	input  logic [RAW_BITS-1:0]                         raw_y,
	input  logic                                        pen_down_after,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic                                        valid_res,
	output logic [tcsm_pkg::PIX_W-1:0]                  screen_x,
	output logic [tcsm_pkg::PIX_W-1:0]                  screen_y,
	input  logic                                        cfg_we,
	input  logic [tcsm_pkg::CFG_IDX_W-1:0]              cfg_addr,
	input  logic [(RAW_BITS > tcsm_pkg::SIZE_W ? RAW_BITS : tcsm_pkg::SIZE_W)-1:0] cfg_wdata
);

	localparam int NW = RAW_BITS + 12;
	localparam logic [RAW_BITS-1:0] CAL_HI_RST = RAW_BITS'(4095);

	logic [RAW_BITS-1:0]           x_low_q, x_high_q, y_low_q, y_high_q;
	logic [tcsm_pkg::MARGIN_W-1:0] marg_x_q, marg_y_q;
	logic [tcsm_pkg::SIZE_W-1:0]   width_q, height_q;
	logic [tcsm_pkg::PIX_W-1:0]    szm1_x, szm1_y;
	logic [RAW_BITS-1:0]           den_x, den_y;
	logic                          en;
	tcsm_pkg::meta_t               meta_in;
	tcsm_pkg::meta_t               mf_x, mf_y, md_x, md_y, mb_x, mb_y;
	logic [NW-1:0]                 nm_x, nm_y, q_x, q_y;
	logic                          ng_x, ng_y, nd_x, nd_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= CAL_HI_RST;
			y_low_q  <= '0;
			y_high_q <= CAL_HI_RST;
			marg_x_q <= tcsm_pkg::MARGIN_RST;
			marg_y_q <= tcsm_pkg::MARGIN_RST;
			width_q  <= tcsm_pkg::WIDTH_RST;
			height_q <= tcsm_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tcsm_pkg::CFG_X_LOW:  x_low_q  <= cfg_wdata[RAW_BITS-1:0];
				tcsm_pkg::CFG_X_HIGH: x_high_q <= cfg_wdata[RAW_BITS-1:0];
				tcsm_pkg::CFG_Y_LOW:  y_low_q  <= cfg_wdata[RAW_BITS-1:0];
				tcsm_pkg::CFG_Y_HIGH: y_high_q <= cfg_wdata[RAW_BITS-1:0];
				tcsm_pkg::CFG_MARG_X: marg_x_q <= cfg_wdata[tcsm_pkg::MARGIN_W-1:0];
				tcsm_pkg::CFG_MARG_Y: marg_y_q <= cfg_wdata[tcsm_pkg::MARGIN_W-1:0];
				tcsm_pkg::CFG_WIDTH:  width_q  <= cfg_wdata[tcsm_pkg::SIZE_W-1:0];
				tcsm_pkg::CFG_HEIGHT: height_q <= cfg_wdata[tcsm_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign szm1_x = tcsm_pkg::size_m1(width_q);
	assign szm1_y = tcsm_pkg::size_m1(height_q);
	assign den_x  = (x_high_q >= x_low_q) ? x_high_q - x_low_q : x_low_q - x_high_q;
	assign den_y  = (y_high_q >= y_low_q) ? y_high_q - y_low_q : y_low_q - y_high_q;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign meta_in  = '{vld: in_valid, ok: pen_down_before && pen_down_after};

	tcsm_front #(.RAW_BITS(RAW_BITS), .NW(NW)) u_front_x (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(meta_in), .raw(raw_x),
		.low(x_low_q), .high(x_high_q), .margin(marg_x_q), .szm1(szm1_x),
		.meta_out(mf_x), .num_mag(nm_x), .num_neg(ng_x)
	);

	tcsm_front #(.RAW_BITS(RAW_BITS), .NW(NW)) u_front_y (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(meta_in), .raw(raw_y),
		.low(y_low_q), .high(y_high_q), .margin(marg_y_q), .szm1(szm1_y),
		.meta_out(mf_y), .num_mag(nm_y), .num_neg(ng_y)
	);

	tcsm_div #(.NW(NW), .DW(RAW_BITS)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(mf_x), .neg_in(ng_x),
		.n_in(nm_x), .d(den_x), .meta_out(md_x), .neg_out(nd_x), .q_out(q_x)
	);

	tcsm_div #(.NW(NW), .DW(RAW_BITS)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(mf_y), .neg_in(ng_y),
		.n_in(nm_y), .d(den_y), .meta_out(md_y), .neg_out(nd_y), .q_out(q_y)
	);

	tcsm_back #(.NW(NW)) u_back_x (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(md_x), .neg_in(nd_x),
		.q_in(q_x), .den_zero(den_x == '0), .margin(marg_x_q), .szm1(szm1_x),
		.meta_out(mb_x), .pix(screen_x)
	);

	tcsm_back #(.NW(NW)) u_back_y (
		.clk(clk), .arst_n(arst_n), .en(en), .meta_in(md_y), .neg_in(nd_y),
		.q_in(q_y), .den_zero(den_y == '0), .margin(marg_y_q), .szm1(szm1_y),
		.meta_out(mb_y), .pix(screen_y)
	);

	assign out_valid = mb_x.vld;
	assign valid_res = mb_x.ok;

	// both axis pipelines must stay in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mb_x == mb_y && md_x == md_y && mf_x == mf_y)
		else $error("axis pipelines out of step");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> screen_x == '0 && screen_y == '0)
		else $error("invalid sample with nonzero coordinates");

	a_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> screen_x <= szm1_x && screen_y <= szm1_y)
		else $error("coordinate beyond screen");

endmodule
